// ----- rtl/ssa_pkg.sv -----
`default_nettype none

package ssa_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 8;

  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned PRESS_W    = 24;
  localparam int unsigned HUMID_W    = 17;
  localparam int unsigned SAMP_W     = 4;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned DISC_W     = 2;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // common signed width for the change check, and the magnitude/product widths
  localparam int unsigned DIFF_W = PRESS_W + 2;
  localparam int unsigned MAG_W  = PRESS_W + 1;
  localparam int unsigned PROD_W = MAG_W + TOL_W;

  localparam logic [TEMP_W-1:0]  TEMP_SENTINEL       = 15'h7060;  // -4000
  localparam logic [PRESS_W-1:0] PRESS_SENTINEL_LOW  = 24'd3000000;
  localparam logic [PRESS_W-1:0] PRESS_SENTINEL_HIGH = 24'd11000000;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_READING = 1'b1;

  localparam logic [SAMP_W-1:0]  SAMPLES_RST  = 4'd5;
  localparam logic [RETRY_W-1:0] RETRIES_RST  = 8'd10;
  localparam logic [DISC_W-1:0]  DISCARDS_RST = 2'd2;
  localparam logic [TOL_W-1:0]   TEMP_TOL_RST  = 16'd1000;
  localparam logic [TOL_W-1:0]   PRESS_TOL_RST = 16'd10000;
  localparam logic [TOL_W-1:0]   HUMID_TOL_RST = 16'd200;
  localparam logic [RETRY_W-1:0] RETRY_MAX     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES,
    REG_RETRIES,
    REG_DISCARDS,
    REG_TEMP_TOL,
    REG_PRESS_TOL,
    REG_HUMID_TOL
  } ssa_reg_e;

  typedef enum logic [1:0] {
    CH_TEMP,
    CH_PRESS,
    CH_HUMID
  } ssa_chan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_CMP,
    ST_RESOLVE,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } ssa_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } ssa_div_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ssa_div.sv -----
`default_nettype none

// Three restoring dividers in lock step, one quotient bit per cycle.
module ssa_div import ssa_pkg::*; #(
  parameter int unsigned DW = 27,
  parameter int unsigned CW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] dvsr_i,
  input  wire logic [DW-1:0] a_i,
  input  wire logic [DW-1:0] b_i,
  input  wire logic [DW-1:0] c_i,
  output logic      [DW-1:0] qa_o,
  output logic      [DW-1:0] qb_o,
  output logic      [DW-1:0] qc_o,
  output ssa_div_sts_t       sts_o
);

  localparam int unsigned IW = $clog2(DW + 1);

  logic [DW-1:0] num_q [3];
  logic [DW-1:0] num_d [3];
  logic [CW-1:0] rem_q [3];
  logic [CW-1:0] rem_d [3];
  logic [CW-1:0] dvsr_q;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  always_comb begin
    logic [CW:0] trial;
    logic        qbit;
    trial  = '0;
    qbit   = 1'b0;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      num_d[l] = num_q[l];
      rem_d[l] = rem_q[l];
    end
    if (start_i) begin
      num_d[0] = a_i;
      num_d[1] = b_i;
      num_d[2] = c_i;
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = '0;
      end
      cnt_d  = IW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int l = 0; l < 3; l++) begin
        trial = {rem_q[l], num_q[l][DW-1]};
        qbit  = (trial >= {1'b0, dvsr_q});
        if (qbit) begin
          rem_d[l] = CW'(trial - {1'b0, dvsr_q});
        end else begin
          rem_d[l] = trial[CW-1:0];
        end
        num_d[l] = {num_q[l][DW-2:0], qbit};
      end
      cnt_d = cnt_q - IW'(1);
      if (cnt_q == IW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      num_q[l] <= num_d[l];
      rem_q[l] <= rem_d[l];
    end
    if (start_i) begin
      dvsr_q <= dvsr_i;
    end
  end

  assign qa_o       = num_q[0];
  assign qb_o       = num_q[1];
  assign qc_o       = num_q[2];
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

// ----- rtl/sensor_settle_average.sv -----
// Flow: a word that ends no run frees the input once its decision, and any change check and
//   accumulation, are done. A word that closes a run with accepted readings starts the divider,
//   one quotient bit per cycle over the pressure sum width, and its result is loaded into the
//   output register once the divider is done and that register is free; a run that closes with
//   no accepted reading reports without the divider. Input is taken one word at a time: the next
//   waits until the last is done. The change check runs the shared multiplier once per channel.
//   A result waiting in the output register stalls input only when the next run closes. Reset:
//   asynchronous, active low; configuration and control registers take their defaults and no run is open.
`default_nettype none

module sensor_settle_average import ssa_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  cmd_i,
  input  wire logic                  read_ok_i,
  input  wire logic [TEMP_W-1:0]     temperature_i,
  input  wire logic [PRESS_W-1:0]    pressure_i,
  input  wire logic [HUMID_W-1:0]    humidity_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       success_o,
  output logic [TEMP_W-1:0]          avg_temperature_o,
  output logic [PRESS_W-1:0]         avg_pressure_o,
  output logic [HUMID_W-1:0]         avg_humidity_o
);

  localparam int unsigned LOG_N = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CMP_W = (CNT_W > SAMP_W) ? CNT_W : SAMP_W;
  localparam int unsigned ST_W  = TEMP_W + LOG_N;
  localparam int unsigned SP_W  = PRESS_W + LOG_N;
  localparam int unsigned SH_W  = HUMID_W + LOG_N;
  localparam int unsigned DW    = SP_W;

  // configuration
  logic [SAMP_W-1:0]  samples_q, samples_d;
  logic [RETRY_W-1:0] retries_q, retries_d;
  logic [DISC_W-1:0]  discards_q, discards_d;
  logic [TOL_W-1:0]   tol_t_q, tol_t_d, tol_p_q, tol_p_d, tol_h_q, tol_h_d;

  // run state
  ssa_state_e         state_q, state_d;
  logic               run_q, run_d;
  logic [DISC_W-1:0]  disc_q, disc_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [TEMP_W-1:0]  prev_t_q, prev_t_d;
  logic [PRESS_W-1:0] prev_p_q, prev_p_d;
  logic [HUMID_W-1:0] prev_h_q, prev_h_d;
  logic [ST_W-1:0]    sum_t_q, sum_t_d;
  logic [SP_W-1:0]    sum_p_q, sum_p_d;
  logic [SH_W-1:0]    sum_h_q, sum_h_d;

  // held input word
  logic               cmd_q, ok_q;
  logic [TEMP_W-1:0]  t_q;
  logic [PRESS_W-1:0] p_q;
  logic [HUMID_W-1:0] h_q;

  // change check
  ssa_chan_e          ch_q, ch_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [MAG_W-1:0]   pmag_q, pmag_d;
  logic               nz_q, nz_d;
  logic               restart_q, restart_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               success_q;
  logic [TEMP_W-1:0]  avg_t_q;
  logic [PRESS_W-1:0] avg_p_q;
  logic [HUMID_W-1:0] avg_h_q;

  logic               in_acc;
  logic               good;
  logic               budget;
  logic [RETRY_W-1:0] retry_bump;
  logic [CMP_W-1:0]   npos;
  logic               run_end;
  logic               div_start;
  logic               load_out;
  logic               sum_neg;
  logic [ST_W-1:0]    sum_t_mag;
  logic [DW-1:0]      qa, qb, qc;
  ssa_div_sts_t       div_sts;
  logic [TEMP_W-1:0]  quot_t;

  logic signed [DIFF_W-1:0] now_s, prev_s, diff_s;
  logic [DIFF_W-1:0]        dmag_w, pmag_w;
  logic [TOL_W-1:0]         inv;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;

  always_comb begin
    samples_d  = samples_q;
    retries_d  = retries_q;
    discards_d = discards_q;
    tol_t_d    = tol_t_q;
    tol_p_d    = tol_p_q;
    tol_h_d    = tol_h_q;
    if (cfg_valid_i) begin
      case (ssa_reg_e'(cfg_index_i))
        REG_SAMPLES:   samples_d  = cfg_data_i[SAMP_W-1:0];
        REG_RETRIES:   retries_d  = cfg_data_i[RETRY_W-1:0];
        REG_DISCARDS:  discards_d = cfg_data_i[DISC_W-1:0];
        REG_TEMP_TOL:  tol_t_d    = cfg_data_i[TOL_W-1:0];
        REG_PRESS_TOL: tol_p_d    = cfg_data_i[TOL_W-1:0];
        REG_HUMID_TOL: tol_h_d    = cfg_data_i[TOL_W-1:0];
        default:       ;
      endcase
    end
  end

  // a sentinel value counts as a failed read
  assign good = ok_q && (t_q != TEMP_SENTINEL) && (p_q != PRESS_SENTINEL_LOW)
                && (p_q != PRESS_SENTINEL_HIGH);
  assign budget     = (retry_q < retries_q);
  assign retry_bump = (retry_q == RETRY_MAX) ? retry_q : retry_q + RETRY_W'(1);

  always_comb begin
    if (samples_q == '0) begin
      npos = CMP_W'(1);
    end else if (CMP_W'(samples_q) > CMP_W'(MAX_SAMPLES)) begin
      npos = CMP_W'(MAX_SAMPLES);
    end else begin
      npos = CMP_W'(samples_q);
    end
  end
  assign run_end = (CMP_W'(pos_q) >= npos);

  // shared multiplier operands
  always_comb begin
    case (ch_q)
      CH_TEMP: begin
        now_s  = $signed({{(DIFF_W-TEMP_W){t_q[TEMP_W-1]}}, t_q});
        prev_s = $signed({{(DIFF_W-TEMP_W){prev_t_q[TEMP_W-1]}}, prev_t_q});
        inv    = tol_t_q;
      end
      CH_PRESS: begin
        now_s  = $signed({{(DIFF_W-PRESS_W){1'b0}}, p_q});
        prev_s = $signed({{(DIFF_W-PRESS_W){1'b0}}, prev_p_q});
        inv    = tol_p_q;
      end
      CH_HUMID: begin
        now_s  = $signed({{(DIFF_W-HUMID_W){1'b0}}, h_q});
        prev_s = $signed({{(DIFF_W-HUMID_W){1'b0}}, prev_h_q});
        inv    = tol_h_q;
      end
      default: begin
        now_s  = '0;
        prev_s = '0;
        inv    = '0;
      end
    endcase
  end
  assign diff_s = now_s - prev_s;
  assign dmag_w = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
  assign pmag_w = prev_s[DIFF_W-1] ? DIFF_W'(-prev_s) : DIFF_W'(prev_s);

  assign sum_neg   = sum_t_q[ST_W-1];
  assign sum_t_mag = sum_neg ? (~sum_t_q + ST_W'(1)) : sum_t_q;
  assign quot_t    = qa[TEMP_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (cmd_q == CMD_START || !run_q || disc_q != '0) begin
          state_d = ST_IDLE;
        end else if (!good) begin
          state_d = budget ? ST_IDLE : ST_CHECK;
        end else if (budget && pos_q != '0) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_ACCUM;
        end
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        state_d = (ch_q == CH_HUMID) ? ST_RESOLVE : ST_MUL;
      end
      ST_RESOLVE: begin
        state_d = restart_q ? ST_IDLE : ST_ACCUM;
      end
      ST_ACCUM: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!run_end) begin
          state_d = ST_IDLE;
        end else if (count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    run_d     = run_q;
    disc_d    = disc_q;
    pos_d     = pos_q;
    count_d   = count_q;
    retry_d   = retry_q;
    prev_t_d  = prev_t_q;
    prev_p_d  = prev_p_q;
    prev_h_d  = prev_h_q;
    sum_t_d   = sum_t_q;
    sum_p_d   = sum_p_q;
    sum_h_d   = sum_h_q;
    ch_d      = ch_q;
    prod_d    = prod_q;
    pmag_d    = pmag_q;
    nz_d      = nz_q;
    restart_d = restart_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_DECIDE: begin
        if (cmd_q == CMD_START) begin
          run_d    = 1'b1;
          disc_d   = discards_q;
          pos_d    = '0;
          count_d  = '0;
          retry_d  = '0;
          prev_t_d = '0;
          prev_p_d = '0;
          prev_h_d = '0;
          sum_t_d  = '0;
          sum_p_d  = '0;
          sum_h_d  = '0;
        end else if (!run_q) begin
          // drop: no run open
        end else if (disc_q != '0) begin
          disc_d = disc_q - DISC_W'(1);
        end else if (!good) begin
          retry_d = retry_bump;
          if (!budget) begin
            pos_d = pos_q + CNT_W'(1);
          end
        end else begin
          ch_d      = CH_TEMP;
          restart_d = 1'b0;
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(dmag_w[MAG_W-1:0]) * PROD_W'(inv);
        pmag_d = pmag_w[MAG_W-1:0];
        nz_d   = (diff_s != '0);
      end
      ST_CMP: begin
        if (nz_q && prod_q >= PROD_W'(pmag_q)) begin
          restart_d = 1'b1;
        end
        case (ch_q)
          CH_TEMP:  ch_d = CH_PRESS;
          CH_PRESS: ch_d = CH_HUMID;
          default:  ch_d = CH_TEMP;
        endcase
      end
      ST_RESOLVE: begin
        if (restart_q) begin
          retry_d = retry_bump;
          pos_d   = '0;
          count_d = '0;
          sum_t_d = '0;
          sum_p_d = '0;
          sum_h_d = '0;
        end
      end
      ST_ACCUM: begin
        prev_t_d = t_q;
        prev_p_d = p_q;
        prev_h_d = h_q;
        sum_t_d  = sum_t_q + {{(ST_W-TEMP_W){t_q[TEMP_W-1]}}, t_q};
        sum_p_d  = sum_p_q + {{(SP_W-PRESS_W){1'b0}}, p_q};
        sum_h_d  = sum_h_q + {{(SH_W-HUMID_W){1'b0}}, h_q};
        count_d  = count_q + CNT_W'(1);
        pos_d    = pos_q + CNT_W'(1);
      end
      ST_CHECK: begin
        if (run_end) begin
          run_d     = 1'b0;
          div_start = (count_q != '0);
        end
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  ssa_div #(
    .DW (DW),
    .CW (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvsr_i  (count_q),
    .a_i     ({{(DW-ST_W){1'b0}}, sum_t_mag}),
    .b_i     (sum_p_q),
    .c_i     ({{(DW-SH_W){1'b0}}, sum_h_q}),
    .qa_o    (qa),
    .qb_o    (qb),
    .qc_o    (qc),
    .sts_o   (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q   <= SAMPLES_RST;
      retries_q   <= RETRIES_RST;
      discards_q  <= DISCARDS_RST;
      tol_t_q     <= TEMP_TOL_RST;
      tol_p_q     <= PRESS_TOL_RST;
      tol_h_q     <= HUMID_TOL_RST;
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      disc_q      <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      retry_q     <= '0;
      prev_t_q    <= '0;
      prev_p_q    <= '0;
      prev_h_q    <= '0;
      sum_t_q     <= '0;
      sum_p_q     <= '0;
      sum_h_q     <= '0;
      ch_q        <= CH_TEMP;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      samples_q   <= samples_d;
      retries_q   <= retries_d;
      discards_q  <= discards_d;
      tol_t_q     <= tol_t_d;
      tol_p_q     <= tol_p_d;
      tol_h_q     <= tol_h_d;
      state_q     <= state_d;
      run_q       <= run_d;
      disc_q      <= disc_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      retry_q     <= retry_d;
      prev_t_q    <= prev_t_d;
      prev_p_q    <= prev_p_d;
      prev_h_q    <= prev_h_d;
      sum_t_q     <= sum_t_d;
      sum_p_q     <= sum_p_d;
      sum_h_q     <= sum_h_d;
      ch_q        <= ch_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i;
      ok_q  <= read_ok_i;
      t_q   <= temperature_i;
      p_q   <= pressure_i;
      h_q   <= humidity_i;
    end
    prod_q <= prod_d;
    pmag_q <= pmag_d;
    nz_q   <= nz_d;
    if (load_out) begin
      success_q <= (count_q != '0);
      if (count_q == '0) begin
        avg_t_q <= '0;
        avg_p_q <= '0;
        avg_h_q <= '0;
      end else begin
        // truncate toward zero: divide the magnitude, then restore the sign
        avg_t_q <= sum_neg ? (~quot_t + TEMP_W'(1)) : quot_t;
        avg_p_q <= qb[PRESS_W-1:0];
        avg_h_q <= qc[HUMID_W-1:0];
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign success_o         = success_q;
  assign avg_temperature_o = avg_t_q;
  assign avg_pressure_o    = avg_p_q;
  assign avg_humidity_o    = avg_h_q;

endmodule

`default_nettype wire

// ----- rtl/ssa_chk.sv -----
`default_nettype none

module ssa_chk import ssa_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  cmd_i,
  input wire logic                  read_ok_i,
  input wire logic [TEMP_W-1:0]     temperature_i,
  input wire logic [PRESS_W-1:0]    pressure_i,
  input wire logic [HUMID_W-1:0]    humidity_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic                  success_o,
  input wire logic [TEMP_W-1:0]     avg_temperature_o,
  input wire logic [PRESS_W-1:0]    avg_pressure_o,
  input wire logic [HUMID_W-1:0]    avg_humidity_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(success_o)
      && $stable(avg_temperature_o) && $stable(avg_pressure_o)
      && $stable(avg_humidity_o))
    else $error("result word changed while stalled");

  // a failed run reports all averages as zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> avg_temperature_o == '0 && avg_pressure_o == '0
      && avg_humidity_o == '0)
    else $error("failed run with nonzero averages");

  // a taken word keeps the block busy and cannot produce a result the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !$rose(out_valid_o))
    else $error("input ready or result right after a taken word");

endmodule

bind sensor_settle_average ssa_chk u_ssa_chk (.*);

`default_nettype wire

// ----- tb/settle_average_checker.sv -----
`default_nettype none

module settle_average_checker import ssa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic                  cmd_i,
  input  wire logic                  read_ok_i,
  input  wire logic [TEMP_W-1:0]     temperature_i,
  input  wire logic [PRESS_W-1:0]    pressure_i,
  input  wire logic [HUMID_W-1:0]    humidity_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic                  success_i,
  input  wire logic [TEMP_W-1:0]     avg_temperature_i,
  input  wire logic [PRESS_W-1:0]    avg_pressure_i,
  input  wire logic [HUMID_W-1:0]    avg_humidity_i,
  output int                         mismatches_o,
  output int                         pending_o
);

  typedef struct {
    logic               success;
    logic [TEMP_W-1:0]  temperature;
    logic [PRESS_W-1:0] pressure;
    logic [HUMID_W-1:0] humidity;
  } run_mean_t;

  run_mean_t expected_means[$];

  logic [SAMP_W-1:0]  samples_cfg;
  logic [RETRY_W-1:0] retries_cfg;
  logic [DISC_W-1:0]  discards_cfg;
  logic [TOL_W-1:0]   temp_tol_cfg;
  logic [TOL_W-1:0]   press_tol_cfg;
  logic [TOL_W-1:0]   humid_tol_cfg;

  logic        run_open;
  int unsigned discards_left;
  int unsigned position;
  int unsigned accepted_count;
  int unsigned retry_count;
  longint      prev_temp, prev_press, prev_humid;
  longint      sum_temp, sum_press, sum_humid;

  function automatic logic beyond_tolerance(longint now, longint prev, longint inv);
    longint diff;
    diff = now - prev;
    if (diff == 0) return 1'b0;
    return ((diff < 0 ? -diff : diff) * inv) >= (prev < 0 ? -prev : prev);
  endfunction

  task automatic clear_run();
    run_open       = 1'b0;
    discards_left  = 0;
    position       = 0;
    accepted_count = 0;
    retry_count    = 0;
    prev_temp      = 0;
    prev_press     = 0;
    prev_humid     = 0;
    sum_temp       = 0;
    sum_press      = 0;
    sum_humid      = 0;
  endtask

  task automatic bump_retry();
    if (retry_count < RETRY_MAX) retry_count++;
  endtask

  // Advance the run by one accepted word; queue the means when the run closes.
  task automatic take_word(input logic cmd, input logic read_ok,
                           input logic [TEMP_W-1:0] t_raw,
                           input logic [PRESS_W-1:0] p_raw,
                           input logic [HUMID_W-1:0] h_raw);
    longint      t, p, h, quot;
    logic        ok, budget, restart, advance;
    int unsigned n_pos;
    run_mean_t   m;
    t = longint'($signed(t_raw));
    p = longint'(p_raw);
    h = longint'(h_raw);
    ok = read_ok;
    advance = 1'b0;
    if (cmd == CMD_START) begin
      clear_run();
      run_open = 1'b1;
      discards_left = discards_cfg;
    end else if (run_open) begin
      if (discards_left != 0) begin
        discards_left--;
      end else begin
        if (t_raw == TEMP_SENTINEL || p_raw == PRESS_SENTINEL_LOW ||
            p_raw == PRESS_SENTINEL_HIGH)
          ok = 1'b0;
        budget = retry_count < retries_cfg;
        if (!ok) begin
          bump_retry();
          advance = !budget;
        end else begin
          restart = budget && position != 0 &&
                    (beyond_tolerance(t, prev_temp, temp_tol_cfg) |
                     beyond_tolerance(p, prev_press, press_tol_cfg) |
                     beyond_tolerance(h, prev_humid, humid_tol_cfg));
          if (restart) begin
            // previous values survive a restart, and no new settling
            bump_retry();
            position       = 0;
            accepted_count = 0;
            sum_temp       = 0;
            sum_press      = 0;
            sum_humid      = 0;
          end else begin
            prev_temp  = t;
            prev_press = p;
            prev_humid = h;
            sum_temp  += t;
            sum_press += p;
            sum_humid += h;
            accepted_count++;
            advance = 1'b1;
          end
        end
      end
    end
    if (advance) begin
      position++;
      n_pos = (samples_cfg == 0) ? 1 :
              (samples_cfg > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : samples_cfg;
      if (position >= n_pos) begin
        run_open = 1'b0;
        if (accepted_count == 0) begin
          m.success     = 1'b0;
          m.temperature = '0;
          m.pressure    = '0;
          m.humidity    = '0;
        end else begin
          m.success     = 1'b1;
          quot          = sum_temp / longint'(accepted_count);
          m.temperature = quot[TEMP_W-1:0];
          quot          = sum_press / longint'(accepted_count);
          m.pressure    = quot[PRESS_W-1:0];
          quot          = sum_humid / longint'(accepted_count);
          m.humidity    = quot[HUMID_W-1:0];
        end
        expected_means.push_back(m);
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_mean_t m;
    if (!rst_ni) begin
      samples_cfg   = SAMPLES_RST;
      retries_cfg   = RETRIES_RST;
      discards_cfg  = DISCARDS_RST;
      temp_tol_cfg  = TEMP_TOL_RST;
      press_tol_cfg = PRESS_TOL_RST;
      humid_tol_cfg = HUMID_TOL_RST;
      clear_run();
      expected_means.delete();
      mismatches_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result, expected none, got success %0b avg %0d %0d %0d",
                   $time, success_i, $signed(avg_temperature_i), avg_pressure_i,
                   avg_humidity_i);
          mismatches_o++;
        end else begin
          m = expected_means.pop_front();
          compare_field("success", m.success, success_i);
          compare_field("avg_temperature", $signed(m.temperature),
                        $signed(avg_temperature_i));
          compare_field("avg_pressure", m.pressure, avg_pressure_i);
          compare_field("avg_humidity", m.humidity, avg_humidity_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SAMPLES:   samples_cfg   = cfg_data_i[SAMP_W-1:0];
          REG_RETRIES:   retries_cfg   = cfg_data_i[RETRY_W-1:0];
          REG_DISCARDS:  discards_cfg  = cfg_data_i[DISC_W-1:0];
          REG_TEMP_TOL:  temp_tol_cfg  = cfg_data_i[TOL_W-1:0];
          REG_PRESS_TOL: press_tol_cfg = cfg_data_i[TOL_W-1:0];
          REG_HUMID_TOL: humid_tol_cfg = cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        take_word(cmd_i, read_ok_i, temperature_i, pressure_i, humidity_i);
    end
    pending_o = expected_means.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb_sensor_settle_average.sv -----
`default_nettype none

module tb_sensor_settle_average;
  import ssa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd_w = CMD_START;
  logic                  read_ok_w = 1'b0;
  logic [TEMP_W-1:0]     temperature_w = '0;
  logic [PRESS_W-1:0]    pressure_w = '0;
  logic [HUMID_W-1:0]    humidity_w = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  success;
  logic [TEMP_W-1:0]     avg_temperature;
  logic [PRESS_W-1:0]    avg_pressure;
  logic [HUMID_W-1:0]    avg_humidity;

  int mismatches;
  int pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;

  // stimulus-side copy of the settings, used only to shape run lengths
  int unsigned cur_samples = 32'(SAMPLES_RST);
  int unsigned cur_discards = 32'(DISCARDS_RST);

  int          base_temp;
  int unsigned base_press;
  int unsigned base_humid;

  sensor_settle_average dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .cmd_i             (cmd_w),
    .read_ok_i         (read_ok_w),
    .temperature_i     (temperature_w),
    .pressure_i        (pressure_w),
    .humidity_i        (humidity_w),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .success_o         (success),
    .avg_temperature_o (avg_temperature),
    .avg_pressure_o    (avg_pressure),
    .avg_humidity_o    (avg_humidity)
  );

  settle_average_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .cmd_i             (cmd_w),
    .read_ok_i         (read_ok_w),
    .temperature_i     (temperature_w),
    .pressure_i        (pressure_w),
    .humidity_i        (humidity_w),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .success_i         (success),
    .avg_temperature_i (avg_temperature),
    .avg_pressure_i    (avg_pressure),
    .avg_humidity_i    (avg_humidity),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic cmd, input logic ok, input int t,
                           input int unsigned p, input int unsigned h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    cmd_w         <= cmd;
    read_ok_w     <= ok;
    temperature_w <= t[TEMP_W-1:0];
    pressure_w    <= p[PRESS_W-1:0];
    humidity_w    <= h[HUMID_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is in and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input ssa_reg_e idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned samples, input int unsigned retries,
                           input int unsigned discards, input int unsigned temp_tol,
                           input int unsigned press_tol, input int unsigned humid_tol);
    drain();
    write_reg(REG_SAMPLES, samples);
    write_reg(REG_RETRIES, retries);
    write_reg(REG_DISCARDS, discards);
    write_reg(REG_TEMP_TOL, temp_tol);
    write_reg(REG_PRESS_TOL, press_tol);
    write_reg(REG_HUMID_TOL, humid_tol);
    cfg_valid <= 1'b0;
    cur_samples  = samples;
    cur_discards = discards;
  endtask

  task automatic new_base();
    if ($urandom_range(9) == 0) begin
      // zero previous values exercise the divide-by-zero change rule
      base_temp  = 0;
      base_humid = 0;
    end else begin
      base_temp  = int'($urandom_range(12500)) - 4000;
      base_humid = $urandom_range(102400);
    end
    base_press = $urandom_range(11000000, 3000000);
  endtask

  task automatic send_reading();
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_word(CMD_READING, 1'b1, base_temp, base_press, base_humid);
    end else if (pick < 77) begin
      v = base_temp + int'($urandom_range(6)) - 3;
      base_temp = (v < -4000) ? -4000 : (v > 8500) ? 8500 : v;
      v = int'(base_press) + int'($urandom_range(600)) - 300;
      base_press = (v < 3000000) ? 3000000 : (v > 11000000) ? 11000000 : v;
      v = int'(base_humid) + int'($urandom_range(100)) - 50;
      base_humid = (v < 0) ? 0 : (v > 102400) ? 102400 : v;
      send_word(CMD_READING, 1'b1, base_temp, base_press, base_humid);
    end else if (pick < 85) begin
      new_base();
      send_word(CMD_READING, 1'b1, base_temp, base_press, base_humid);
    end else if (pick < 91) begin
      send_word(CMD_READING, 1'b0, int'($urandom_range(12500)) - 4000,
                $urandom_range(11000000, 3000000), $urandom_range(102400));
    end else if (pick < 94) begin
      send_word(CMD_READING, 1'b1, -4000, base_press, base_humid);
    end else if (pick < 97) begin
      send_word(CMD_READING, 1'b1, base_temp, 32'(PRESS_SENTINEL_LOW), base_humid);
    end else begin
      send_word(CMD_READING, 1'b1, base_temp, 32'(PRESS_SENTINEL_HIGH), base_humid);
    end
  endtask

  // Mostly whole runs with random content; the rest stray readings and cut runs.
  task automatic random_runs(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    int unsigned n_pos;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 6) begin
        send_reading();
      end else begin
        n_pos = (cur_samples == 0) ? 1 :
                (cur_samples > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : cur_samples;
        new_base();
        send_word(CMD_START, 1'($urandom_range(1)), int'($urandom_range(12500)) - 4000,
                  $urandom_range(11000000, 3000000), $urandom_range(102400));
        len = cur_discards + n_pos + $urandom_range(6);
        if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
        repeat (len) send_reading();
        sent += len + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: five positions, two discards, ten retries.
    send_word(CMD_READING, 1'b1, 1000, 5000000, 40000);        // no run open
    send_word(CMD_START, 1'b1, 0, 5000000, 0);
    send_word(CMD_READING, 1'b0, 2000, 5000000, 1000);         // settling, dropped
    send_word(CMD_READING, 1'b1, -4000, 3000000, 0);           // settling, dropped
    send_word(CMD_READING, 1'b1, -4000, 5000000, 500);         // temperature sentinel
    send_word(CMD_READING, 1'b1, 2000, 3000000, 500);          // pressure sentinels
    send_word(CMD_READING, 1'b1, 2000, 11000000, 500);
    send_word(CMD_READING, 1'b0, 2000, 5000000, 500);          // failed read
    send_word(CMD_READING, 1'b1, 8500, 10999999, 102400);
    send_word(CMD_READING, 1'b1, -3999, 3000001, 0);           // big change, restart
    send_word(CMD_START, 1'b1, 8500, 10999999, 102400);        // abandon the run
    send_word(CMD_READING, 1'b1, 100, 4000000, 7);
    send_word(CMD_READING, 1'b1, 100, 4000000, 7);
    send_word(CMD_READING, 1'b1, -3999, 3000001, 0);
    send_word(CMD_READING, 1'b1, -3999, 3000001, 0);
    send_word(CMD_READING, 1'b1, -3999, 3000001, 5);           // change from zero
    repeat (5) send_word(CMD_READING, 1'b1, -3999, 3000001, 5);

    // Spent budget: every position skipped, failure result.
    configure(2, 0, 0, 1000, 10000, 200);
    send_word(CMD_START, 1'b0, 0, 3000000, 0);
    send_word(CMD_READING, 1'b0, 1234, 6000000, 2000);
    send_word(CMD_READING, 1'b1, -4000, 6000000, 2000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(8, 255, 3, 65535, 65535, 65535);
        1: configure(1, 0, 0, 1, 1, 1);
        2: configure(0, 3, 1, 0, 0, 0);
        3: configure(15, 20, 2, 1, 1, 1);
        default: configure($urandom_range(8, 1),
                           ($urandom_range(7) == 0) ? 255 : $urandom_range(15),
                           $urandom_range(3), $urandom_range(65535, 1),
                           $urandom_range(4000, 1), $urandom_range(2000, 1));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      random_runs(130);
    end

    // One-word runs while results are held back, so the block backs up.
    configure(1, 2, 0, 50, 50, 50);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (40) begin
      new_base();
      send_word(CMD_START, 1'b0, 0, 3000000, 0);
      send_word(CMD_READING, 1'b1, base_temp, base_press, base_humid);
    end

    drain();
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sensor_settle_average.f -----
rtl/ssa_pkg.sv
rtl/ssa_div.sv
rtl/sensor_settle_average.sv
rtl/ssa_chk.sv
tb/settle_average_checker.sv
tb/tb_sensor_settle_average.sv
